@@ hw/rtl/epts_pkg.sv @@
// Package: shared types, codes and constants of the pulse edge timestamp logger.
`default_nettype none

package epts_pkg;

   // Ring geometry
   localparam int RING_DEPTH  = 16;
   localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int KIND_W      = 2;
   localparam int REC_ADDR_W  = 1 + KIND_W + SLOT_W;
   localparam int REC_DEPTH   = 2 * 4 * RING_DEPTH;
   localparam int READ_SLOTS  = 16;

   // Response queue geometry
   localparam int RSP_FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W     = (RSP_FIFO_DEPTH > 1) ? $clog2(RSP_FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W     = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int OCC_W          = $clog2(RSP_FIFO_DEPTH + 2);

   // Operation codes
   typedef enum logic [1:0] {
      OP_CAPTURE = 2'd0,
      OP_TICK    = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   // Edge kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LOW_RISE  = 2'd0,
      KIND_HIGH_RISE = 2'd1,
      KIND_HIGH_FALL = 2'd2,
      KIND_LOW_FALL  = 2'd3
   } kind_type;

   // Channel phase status codes
   typedef enum logic [1:0] {
      STAT_NONE      = 2'd0,
      STAT_ROSE_LOW  = 2'd1,
      STAT_FELL_HIGH = 2'd2
   } stat_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        channel;
      logic        threshold;
      logic        level;
      logic [15:0] capture_count;
      logic [3:0]  read_slot;
   } req_type;

   typedef struct packed {
      logic [3:0]  slot_used;
      logic [1:0]  edge_kind;
      logic [31:0] epoch_value;
      logic [15:0] count_value;
      logic [31:0] pulse_total;
      logic [1:0]  phase_status;
   } rsp_type;

   // One stored edge record
   typedef struct packed {
      logic [31:0] epoch;
      logic [15:0] count;
   } rec_type;

   // Record store access from the control unit
   typedef struct packed {
      logic                  wr_en;
      logic [REC_ADDR_W-1:0] wr_addr;
      rec_type               wr_data;
      logic                  rd_en;
      logic [REC_ADDR_W-1:0] rd_addr;
   } rec_req_type;

   // Computed transaction waiting for its record read data
   typedef struct packed {
      logic    valid;
      logic    from_store;
      rsp_type rsp;
   } stage_type;

   // Read slot to ring slot map (read slot modulo ring depth)
   typedef logic [SLOT_W-1:0] slot_lut_type [READ_SLOTS];

   function automatic slot_lut_type build_slot_lut();
      slot_lut_type lut;
      for (int i = 0; i < READ_SLOTS; i++) begin
         lut[i] = SLOT_W'(i % RING_DEPTH);
      end
      return lut;
   endfunction

   localparam slot_lut_type READ_SLOT_LUT = build_slot_lut();

endpackage

`default_nettype wire

@@ hw/rtl/pulse_edge_timestamp_logger_core.sv @@
// Top level: pulse edge timestamp logger core.
//
//  channel | direction | payload  | handshake
//  req     | in        | req_type | req_valid / req_stall (stall driven here)
//  rsp     | out       | rsp_type | rsp_valid / rsp_stall (stall driven by sink)
//
// One transaction may enter every cycle while req_stall is low. Its result
// waits in the compute stage for the registered read of the record store,
// then passes a three-entry response queue isolating req_stall from rsp_stall.
// req_stall rises once the queue and the compute stage together hold three
// transactions, so the stage always finds room at the next edge.
// Synchronous reset clears epoch, pulse counts, slots and status; stored
// records are undefined until a capture writes them.
`default_nettype none

module pulse_edge_timestamp_logger_core
   import epts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic                  accept;
   rec_req_type           rec_req;
   rec_type               rd_data;
   stage_type             stage;
   rsp_type               push_data;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [OCC_W-1:0]      occupancy;
   logic                  head_valid;

   // Stall once the queue could not take the staged result plus one more
   assign occupancy = OCC_W'(fifo_count) + OCC_W'(stage.valid);
   assign req_stall = (occupancy >= OCC_W'(RSP_FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   epts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .rec_req  (rec_req),
      .stage    (stage)
   );

   epts_rec_store u_rec_store (
      .clock   (clock),
      .rec_req (rec_req),
      .rd_data (rd_data)
   );

   // Merge record read data into read results
   always_comb begin
      push_data = stage.rsp;
      if (stage.from_store) begin
         push_data.epoch_value = rd_data.epoch;
         push_data.count_value = rd_data.count;
      end
   end

   epts_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (stage.valid),
      .push_data  (push_data),
      .pop        (!rsp_stall),
      .count      (fifo_count),
      .head_valid (head_valid),
      .head_data  (rsp_data)
   );

   assign rsp_valid = head_valid;

   // Every accepted transaction reaches the compute stage next cycle
   a_accept_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> stage.valid)
      else $error("accepted transaction lost before compute stage");

   // Stage content never appears without an accepted transaction
   a_stage_origin: assert property (@(posedge clock) disable iff (reset)
      stage.valid |-> $past(accept))
      else $error("compute stage valid without accepted transaction");

endmodule

`default_nettype wire

@@ hw/rtl/epts_rec_store.sv @@
// Edge record store: one write port, one registered read port.
`default_nettype none

module epts_rec_store
   import epts_pkg::*;
(
   input  wire logic        clock,
   input  wire rec_req_type rec_req,
   output rec_type          rd_data
);

   rec_type mem_ff [REC_DEPTH];
   rec_type rd_data_ff;

   // Write the record of a capture
   always_ff @(posedge clock) begin
      if (rec_req.wr_en) begin
         mem_ff[rec_req.wr_addr] <= rec_req.wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rec_req.rd_en) begin
         rd_data_ff <= mem_ff[rec_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/epts_ctrl.sv @@
// Control unit: channel state, epoch counter and result formation per transaction.
`default_nettype none

module epts_ctrl
   import epts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req_data,
   output rec_req_type  rec_req,
   output stage_type    stage
);

   logic [31:0]       epoch_ff, epoch_in;
   logic [31:0]       pulse_count_ff [2];
   logic [31:0]       pulse_count_in [2];
   logic [SLOT_W-1:0] pulse_mod_ff   [2];
   logic [SLOT_W-1:0] pulse_mod_in   [2];
   logic [SLOT_W-1:0] write_slot_ff  [2];
   logic [SLOT_W-1:0] write_slot_in  [2];
   logic [1:0]        status_ff      [2];
   logic [1:0]        status_in      [2];

   logic              stage_valid_ff;
   logic              from_store_ff, from_store_in;
   rsp_type           rsp_ff, rsp_in;

   kind_type          kind;
   logic              ch;
   logic [SLOT_W-1:0] slot;

   // Decode the edge kind
   always_comb begin
      ch = req_data.channel;
      if (req_data.threshold == 1'b0) begin
         kind = req_data.level ? KIND_LOW_RISE : KIND_LOW_FALL;
      end else begin
         kind = req_data.level ? KIND_HIGH_RISE : KIND_HIGH_FALL;
      end
   end

   // Compute next state, store access and result
   always_comb begin
      epoch_in       = epoch_ff;
      pulse_count_in = pulse_count_ff;
      pulse_mod_in   = pulse_mod_ff;
      write_slot_in  = write_slot_ff;
      status_in      = status_ff;
      from_store_in  = 1'b0;
      slot           = '0;
      rec_req        = '0;
      rsp_in         = '0;
      rsp_in.epoch_value = epoch_ff;

      case (req_data.op)
         OP_CAPTURE: begin
            slot                  = write_slot_ff[ch];
            rec_req.wr_en         = accept;
            rec_req.wr_addr       = {ch, kind, slot};
            rec_req.wr_data.epoch = epoch_ff;
            rec_req.wr_data.count = req_data.capture_count;
            rsp_in.edge_kind      = kind;
            rsp_in.count_value    = req_data.capture_count;
            case (kind)
               KIND_LOW_RISE: begin
                  status_in[ch] = STAT_ROSE_LOW;
               end
               KIND_HIGH_FALL: begin
                  pulse_count_in[ch] = pulse_count_ff[ch] + 32'd1;
                  pulse_mod_in[ch]   = (pulse_mod_ff[ch] == SLOT_W'(RING_DEPTH - 1)) ?
                                       '0 : pulse_mod_ff[ch] + SLOT_W'(1);
                  status_in[ch]      = STAT_FELL_HIGH;
               end
               KIND_LOW_FALL: begin
                  write_slot_in[ch] = pulse_mod_ff[ch];
               end
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            epoch_in           = epoch_ff + 32'd1;
            rsp_in.epoch_value = epoch_in;
         end
         OP_READ: begin
            slot             = READ_SLOT_LUT[req_data.read_slot];
            rec_req.rd_en    = accept;
            rec_req.rd_addr  = {ch, kind, slot};
            rsp_in.edge_kind = kind;
            from_store_in    = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_in.slot_used    = 4'(slot);
      rsp_in.pulse_total  = pulse_count_in[ch];
      rsp_in.phase_status = status_in[ch];
   end

   // Advance channel state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= '0;
         for (int i = 0; i < 2; i++) begin
            pulse_count_ff[i] <= '0;
            pulse_mod_ff[i]   <= '0;
            write_slot_ff[i]  <= '0;
            status_ff[i]      <= STAT_NONE;
         end
      end else if (accept) begin
         epoch_ff       <= epoch_in;
         pulse_count_ff <= pulse_count_in;
         pulse_mod_ff   <= pulse_mod_in;
         write_slot_ff  <= write_slot_in;
         status_ff      <= status_in;
      end
   end

   // Register the result while the store read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff        <= rsp_in;
         from_store_ff <= from_store_in;
      end
   end

   assign stage.valid      = stage_valid_ff;
   assign stage.from_store = from_store_ff;
   assign stage.rsp        = rsp_ff;

   // A tick advances the epoch by one
   a_tick_epoch: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_TICK) |=> (epoch_ff == $past(epoch_ff) + 32'd1))
      else $error("epoch did not advance on tick");

   // Only an accepted transaction touches the record store
   a_store_gated: assert property (@(posedge clock) disable iff (reset)
      (rec_req.wr_en || rec_req.rd_en) |-> accept)
      else $error("record store accessed without a transaction");

endmodule

`default_nettype wire

@@ hw/rtl/epts_rsp_fifo.sv @@
// Response queue: small register FIFO that decouples the result side.
`default_nettype none

module epts_rsp_fifo
   import epts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_type      push_data,
   input  wire logic         pop,
   output logic [FIFO_CNT_W-1:0] count,
   output logic              head_valid,
   output rsp_type           head_data
);

   rsp_type                 entry_ff [RSP_FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_pop;

   // Advance pointers with wrap
   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(RSP_FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(RSP_FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count      = count_ff;
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Never push into a full queue unless the head leaves at the same edge
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FIFO_CNT_W'(RSP_FIFO_DEPTH) || do_pop))
      else $error("response queue overflow");

endmodule

`default_nettype wire
